/* design/gbe_pkg.sv */
// ----------------------------------------------------------------------------
// gbe_pkg
// Shared types and constants of the gap buffer engine.
// ----------------------------------------------------------------------------
package gbe_pkg;

   // store geometry
   localparam int CAPACITY = 4096;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int POS_W    = 13;
   localparam int CHAR_W   = 8;
   localparam int OP_W     = 3;
   localparam int STS_W    = 3;

   // request codes
   localparam logic [OP_W-1:0] OP_INSERT     = 3'd0;
   localparam logic [OP_W-1:0] OP_DEL_BEFORE = 3'd1;
   localparam logic [OP_W-1:0] OP_DEL_AFTER  = 3'd2;
   localparam logic [OP_W-1:0] OP_MOVE       = 3'd3;
   localparam logic [OP_W-1:0] OP_READ       = 3'd4;
   localparam logic [OP_W-1:0] OP_DEL_RANGE  = 3'd5;
   localparam logic [OP_W-1:0] OP_CLEAR      = 3'd6;

   // status codes
   localparam logic [STS_W-1:0] STS_OK        = 3'd0;
   localparam logic [STS_W-1:0] STS_NO_ROOM   = 3'd1;
   localparam logic [STS_W-1:0] STS_NOTHING   = 3'd2;
   localparam logic [STS_W-1:0] STS_POS_RANGE = 3'd3;
   localparam logic [STS_W-1:0] STS_BAD_RANGE = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]   req_type;
      logic [CHAR_W-1:0] char_in;
      logic [POS_W-1:0]  position;
      logic [POS_W-1:0]  end_position;
   } req_item_type;

   typedef struct packed {
      logic [STS_W-1:0]  status;
      logic [CHAR_W-1:0] char_out;
      logic [POS_W-1:0]  text_size;
      logic [POS_W-1:0]  gap_pos;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MOVE,
      ST_READ_WAIT,
      ST_FINISH
   } state_type;

endpackage

/* design/gbe_ram.sv */
// ----------------------------------------------------------------------------
// gbe_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module gbe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

/* design/gap_buffer_engine_top.sv */
// ----------------------------------------------------------------------------
// gap_buffer_engine_top
// Fixed-capacity gap buffer over a single byte RAM.
// ----------------------------------------------------------------------------
// The text lives in one 4096 x 8 RAM as two runs, one before the gap and one
// after it; only the gap bounds are kept in flops. One request is handled at
// a time. Insert, clear and every rejected request pass from accept through
// decode and finish back to idle; delete before, delete after and read also
// pass the read wait state, since the byte comes back from the RAM in the
// cycle after its address. Move gap and delete range stay in the move state
// until the gap reaches its target; the mover reads one byte and writes the
// byte read in the cycle before on every clock, so the RAM's single read port
// sets the pace at one byte per cycle. A finished response sits in an output
// register, so a new request may be accepted while the previous response is
// stalled. The RAM needs no clearing after reset: a byte is only ever read
// once it has been written as text.
// ----------------------------------------------------------------------------
module gap_buffer_engine_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  gbe_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output gbe_pkg::rsp_item_type rsp_data
);
   import gbe_pkg::*;

   // control state
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      pend_ff, pend_in;

   // gap bounds, reset to an empty text
   logic [POS_W-1:0] gs_ff, gs_in;
   logic [POS_W-1:0] ge_ff, ge_in;

   // request and result payload
   req_item_type      req_ff, req_in;
   logic [POS_W-1:0]  tgt_ff, tgt_in;
   logic [POS_W-1:0]  wid_ff, wid_in;
   logic [ADDR_W-1:0] waddr_ff, waddr_in;
   logic [STS_W-1:0]  sts_ff, sts_in;
   logic [CHAR_W-1:0] cout_ff, cout_in;
   rsp_item_type      rsp_ff, rsp_in;

   // ram port
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [CHAR_W-1:0] wr_data, rd_data;

   // derived values
   logic [POS_W-1:0] cap_pos;
   logic [POS_W-1:0] gap_len;
   logic [POS_W-1:0] text_len;
   logic [POS_W:0]   widened;
   logic             accept;
   logic             rsp_load;
   logic             req_ok;

   assign cap_pos  = POS_W'(CAPACITY);
   assign gap_len  = ge_ff - gs_ff;
   assign text_len = cap_pos - gap_len;
   assign widened  = {1'b0, ge_ff} + {1'b0, wid_ff};
   assign accept   = req_valid && !req_stall;
   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // is the decoded request legal for the current text
   always_comb begin
      unique case (req_ff.req_type)
         OP_INSERT:     req_ok = (gs_ff < ge_ff);
         OP_DEL_BEFORE: req_ok = (gs_ff != '0);
         OP_DEL_AFTER:  req_ok = (ge_ff < cap_pos);
         OP_MOVE:       req_ok = (req_ff.position <= text_len);
         OP_READ:       req_ok = (req_ff.position < text_len);
         OP_DEL_RANGE:  req_ok = (req_ff.position <= req_ff.end_position) &&
                                 (req_ff.end_position <= text_len);
         default:       req_ok = 1'b1;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            state_in = ST_FINISH;
            if (req_ok) begin
               unique case (req_ff.req_type)
                  OP_DEL_BEFORE, OP_DEL_AFTER, OP_READ: state_in = ST_READ_WAIT;
                  OP_MOVE, OP_DEL_RANGE:                state_in = ST_MOVE;
                  default:                              state_in = ST_FINISH;
               endcase
            end
         end
         ST_MOVE: begin
            if (gs_ff == tgt_ff) state_in = ST_FINISH;
         end
         ST_READ_WAIT: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and ram control
   always_comb begin
      req_in       = req_ff;
      gs_in        = gs_ff;
      ge_in        = ge_ff;
      tgt_in       = tgt_ff;
      wid_in       = wid_ff;
      waddr_in     = waddr_ff;
      pend_in      = pend_ff;
      sts_in       = sts_ff;
      cout_in      = cout_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      wr_addr      = gs_ff[ADDR_W-1:0];
      wr_data      = req_ff.char_in;
      rd_en        = 1'b0;
      rd_addr      = gs_ff[ADDR_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) req_in = req_data;
         end
         ST_DECODE: begin
            sts_in  = STS_OK;
            cout_in = '0;
            pend_in = 1'b0;
            tgt_in  = req_ff.position;
            wid_in  = req_ff.end_position - req_ff.position;
            if (!req_ok) begin
               unique case (req_ff.req_type)
                  OP_INSERT:                  sts_in = STS_NO_ROOM;
                  OP_DEL_BEFORE, OP_DEL_AFTER: sts_in = STS_NOTHING;
                  OP_MOVE, OP_READ:           sts_in = STS_POS_RANGE;
                  default:                    sts_in = STS_BAD_RANGE;
               endcase
            end else begin
               unique case (req_ff.req_type)
                  OP_INSERT: begin
                     wr_en = 1'b1;
                     gs_in = gs_ff + 1'b1;
                  end
                  OP_DEL_BEFORE: begin
                     rd_en   = 1'b1;
                     rd_addr = ADDR_W'(gs_ff - 1'b1);
                     gs_in   = gs_ff - 1'b1;
                  end
                  OP_DEL_AFTER: begin
                     rd_en   = 1'b1;
                     rd_addr = ge_ff[ADDR_W-1:0];
                     ge_in   = ge_ff + 1'b1;
                  end
                  OP_READ: begin
                     rd_en = 1'b1;
                     // positions past the gap skip over it
                     if (req_ff.position < gs_ff) begin
                        rd_addr = req_ff.position[ADDR_W-1:0];
                     end else begin
                        rd_addr = ADDR_W'(req_ff.position + gap_len);
                     end
                  end
                  OP_CLEAR: begin
                     gs_in = '0;
                     ge_in = cap_pos;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MOVE: begin
            // write back the byte fetched last cycle
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = waddr_ff;
               wr_data = rd_data;
            end
            if (gs_ff > tgt_ff) begin
               // gap moves left: last byte before it goes to its far end
               rd_en    = 1'b1;
               rd_addr  = ADDR_W'(gs_ff - 1'b1);
               waddr_in = ADDR_W'(ge_ff - 1'b1);
               gs_in    = gs_ff - 1'b1;
               ge_in    = ge_ff - 1'b1;
               pend_in  = 1'b1;
            end else if (gs_ff < tgt_ff) begin
               // gap moves right: first byte after it goes to its near end
               rd_en    = 1'b1;
               rd_addr  = ge_ff[ADDR_W-1:0];
               waddr_in = gs_ff[ADDR_W-1:0];
               gs_in    = gs_ff + 1'b1;
               ge_in    = ge_ff + 1'b1;
               pend_in  = 1'b1;
            end else begin
               pend_in = 1'b0;
               // range delete widens the gap, clamped at the store end
               if (req_ff.req_type == OP_DEL_RANGE) begin
                  if (widened > (POS_W + 1)'(CAPACITY)) begin
                     ge_in = cap_pos;
                  end else begin
                     ge_in = widened[POS_W-1:0];
                  end
               end
            end
         end
         ST_READ_WAIT: begin
            cout_in = rd_data;
         end
         ST_FINISH: begin
            if (rsp_load) begin
               rsp_in.status    = sts_ff;
               rsp_in.char_out  = cout_ff;
               rsp_in.text_size = text_len;
               rsp_in.gap_pos   = gs_ff;
               rsp_valid_in     = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         gs_ff        <= '0;
         ge_ff        <= POS_W'(CAPACITY);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         gs_ff        <= gs_in;
         ge_ff        <= ge_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      tgt_ff   <= tgt_in;
      wid_ff   <= wid_in;
      waddr_ff <= waddr_in;
      sts_ff   <= sts_in;
      cout_ff  <= cout_in;
      rsp_ff   <= rsp_in;
   end

   gbe_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (CAPACITY)
   ) u_text_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

/* verif/tb_gap_buffer_engine_top.sv */
// ----------------------------------------------------------------------------
// tb_gap_buffer_engine_top
// Self-checking bench for the gap buffer engine.
// ----------------------------------------------------------------------------
// An initial block queues every request before the run starts. The queue
// holds a short directed list around an empty and a tiny text, random edits
// on a short text, one pass that builds a longer text and edits it with long
// gap moves at both ends, and then more random edits. A clocked driver offers
// the requests in bursts. A shadow gap buffer predicts the response of each
// accepted request, and a clocked monitor checks every response field by
// field against the oldest prediction. The receiver stalls in changing
// patterns, with one long hold-off.
// ----------------------------------------------------------------------------
module tb_gap_buffer_engine_top;
   import gbe_pkg::*;

   localparam int RANDOM_ITEMS = 1150;
   localparam int FILL_LEN     = 250;     // length of the long text pass
   localparam int CYCLE_LIMIT  = 4000000;
   localparam int SHORT_TEXT   = 200;     // random edits trim the text at or above this
   localparam int HOLDOFF_AT   = 300;     // responses seen before the long hold-off
   localparam int HOLDOFF_LEN  = 600;
   localparam int TAIL_CYCLES  = 20;
   localparam int POS_MAX      = (1 << POS_W) - 1;

   // request code outside the defined set, must leave everything alone
   localparam logic [OP_W-1:0] OP_UNKNOWN = 3'd7;

   // receiver stall patterns
   localparam int RX_FREE     = 0;
   localparam int RX_LIGHT    = 1;
   localparam int RX_HEAVY    = 2;
   localparam int RX_PERIODIC = 3;

   typedef struct {
      req_item_type req;
      bit           drain;     // hold this request until every response is back
   } queued_req_type;

   typedef struct {
      rsp_item_type rsp;
      int           seq;
   } predicted_rsp_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_data;

   gap_buffer_engine_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   queued_req_type    pending_reqs[$];
   predicted_rsp_type predicted_rsps[$];

   // shadow gap buffer, advanced once per accepted request
   logic [CHAR_W-1:0] text_bytes [CAPACITY];
   int gap_lo = 0;
   int gap_hi = CAPACITY;

   // size and gap as the request generator expects them to be
   int gen_len = 0;
   int gen_gap = 0;

   int req_accepts = 0;
   int req_popped  = 0;
   int rsp_seen    = 0;
   int mismatches  = 0;
   int cycles      = 0;

   // ---------------------------------------------------------------------
   // shadow gap buffer
   // ---------------------------------------------------------------------

   // walk the gap one byte at a time until it starts at pos
   function automatic void slide_gap(int pos);
      while (gap_lo > pos) begin
         gap_lo--;
         gap_hi--;
         text_bytes[gap_hi] = text_bytes[gap_lo];
      end
      while (gap_lo < pos) begin
         text_bytes[gap_lo] = text_bytes[gap_hi];
         gap_lo++;
         gap_hi++;
      end
   endfunction

   function automatic rsp_item_type predict_response(req_item_type r);
      rsp_item_type rsp;
      int pos;
      int endp;
      int text_len;
      int phys;
      pos      = int'(r.position);
      endp     = int'(r.end_position);
      text_len = CAPACITY - (gap_hi - gap_lo);
      rsp.status   = STS_OK;
      rsp.char_out = '0;
      case (r.req_type)
         OP_INSERT: begin
            if (gap_lo >= gap_hi) begin
               rsp.status = STS_NO_ROOM;
            end else begin
               text_bytes[gap_lo] = r.char_in;
               gap_lo++;
            end
         end
         OP_DEL_BEFORE: begin
            if (gap_lo == 0) begin
               rsp.status = STS_NOTHING;
            end else begin
               gap_lo--;
               rsp.char_out = text_bytes[gap_lo];
            end
         end
         OP_DEL_AFTER: begin
            if (gap_hi >= CAPACITY) begin
               rsp.status = STS_NOTHING;
            end else begin
               rsp.char_out = text_bytes[gap_hi];
               gap_hi++;
            end
         end
         OP_MOVE: begin
            if (pos > text_len) rsp.status = STS_POS_RANGE;
            else slide_gap(pos);
         end
         OP_READ: begin
            if (pos >= text_len) begin
               rsp.status = STS_POS_RANGE;
            end else begin
               phys = (pos < gap_lo) ? pos : pos + (gap_hi - gap_lo);
               rsp.char_out = text_bytes[phys];
            end
         end
         OP_DEL_RANGE: begin
            if (pos > endp || endp > text_len) begin
               rsp.status = STS_BAD_RANGE;
            end else begin
               slide_gap(pos);
               gap_hi += endp - pos;
               if (gap_hi > CAPACITY) gap_hi = CAPACITY;
            end
         end
         OP_CLEAR: begin
            gap_lo = 0;
            gap_hi = CAPACITY;
         end
         default: ;
      endcase
      rsp.text_size = POS_W'(CAPACITY - (gap_hi - gap_lo));
      rsp.gap_pos   = POS_W'(gap_lo);
      return rsp;
   endfunction

   // ---------------------------------------------------------------------
   // request generation
   // ---------------------------------------------------------------------

   function automatic req_item_type make_req(logic [OP_W-1:0] op, int ch, int pos, int endp);
      req_item_type r;
      r.req_type     = op;
      r.char_in      = CHAR_W'(ch);
      r.position     = POS_W'(pos);
      r.end_position = POS_W'(endp);
      return r;
   endfunction

   // queue a request and keep the generator's view of size and gap in step
   function automatic void push_req(req_item_type r, bit drain);
      queued_req_type q;
      int pos;
      int endp;
      pos  = int'(r.position);
      endp = int'(r.end_position);
      case (r.req_type)
         OP_INSERT: begin
            if (gen_len < CAPACITY) begin
               gen_len++;
               gen_gap++;
            end
         end
         OP_DEL_BEFORE: begin
            if (gen_gap > 0) begin
               gen_len--;
               gen_gap--;
            end
         end
         OP_DEL_AFTER: begin
            if (gen_gap < gen_len) gen_len--;
         end
         OP_MOVE: begin
            if (pos <= gen_len) gen_gap = pos;
         end
         OP_DEL_RANGE: begin
            if (pos <= endp && endp <= gen_len) begin
               gen_gap = pos;
               gen_len -= endp - pos;
            end
         end
         OP_CLEAR: begin
            gen_len = 0;
            gen_gap = 0;
         end
         default: ;
      endcase
      q.req   = r;
      q.drain = drain;
      pending_reqs.insert(pending_reqs.size(), q);
   endfunction

   // one random edit on the current text; fields a request ignores stay random
   function automatic req_item_type random_edit();
      req_item_type r;
      int pick;
      int flavor;
      int a;
      int b;
      r = make_req(OP_INSERT, $urandom_range(255, 0), $urandom_range(POS_MAX, 0),
                   $urandom_range(POS_MAX, 0));
      pick   = $urandom_range(99, 0);
      flavor = $urandom_range(9, 0);
      if (gen_len >= SHORT_TEXT) begin
         // cut most of the text so gap moves stay short
         r.req_type     = OP_DEL_RANGE;
         r.position     = POS_W'($urandom_range(40, 0));
         r.end_position = POS_W'($urandom_range(gen_len, gen_len - 40));
      end else if (pick < 37) begin
         r.req_type = OP_INSERT;
      end else if (pick < 46) begin
         r.req_type = OP_DEL_BEFORE;
      end else if (pick < 55) begin
         r.req_type = OP_DEL_AFTER;
      end else if (pick < 70) begin
         r.req_type = OP_MOVE;
         if (flavor != 0) r.position = POS_W'($urandom_range(gen_len, 0));
         else r.position = POS_W'($urandom_range(POS_MAX, gen_len + 1));
      end else if (pick < 85) begin
         r.req_type = OP_READ;
         if (gen_len > 0 && flavor != 0) r.position = POS_W'($urandom_range(gen_len - 1, 0));
         else r.position = POS_W'($urandom_range(POS_MAX, gen_len));
      end else if (pick < 95) begin
         r.req_type = OP_DEL_RANGE;
         if (flavor < 8) begin
            a = $urandom_range(gen_len, 0);
            b = $urandom_range(gen_len, a);
         end else if (flavor == 8) begin
            // reversed range
            a = $urandom_range(POS_MAX, 1);
            b = $urandom_range(a - 1, 0);
         end else begin
            // range running past the end of the text
            b = $urandom_range(POS_MAX, gen_len + 1);
            a = $urandom_range(b, 0);
         end
         r.position     = POS_W'(a);
         r.end_position = POS_W'(b);
      end else if (pick < 98) begin
         r.req_type = OP_CLEAR;
      end else begin
         r.req_type = OP_UNKNOWN;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------

   task automatic report_mismatch(int seq, string field, int got, int want);
      mismatches++;
      $display("mismatch on request %0d: %s got %0d, predicted %0d", seq, field, got, want);
   endtask

   // ---------------------------------------------------------------------
   // stimulus list and end of run
   // ---------------------------------------------------------------------
   initial begin
      int n;

      // empty text: nothing to delete, nothing to read, moves only to zero
      push_req(make_req(OP_DEL_BEFORE, 0, 0, 0), 1'b0);
      push_req(make_req(OP_DEL_AFTER, 0, 0, 0), 1'b0);
      push_req(make_req(OP_READ, 0, 0, 0), 1'b0);
      push_req(make_req(OP_MOVE, 0, 1, 0), 1'b0);
      push_req(make_req(OP_MOVE, 0, 0, 0), 1'b0);
      // four bytes, among them the extreme character values
      push_req(make_req(OP_INSERT, 8'h00, 0, 0), 1'b0);
      push_req(make_req(OP_INSERT, 8'hff, 0, 0), 1'b0);
      push_req(make_req(OP_INSERT, 8'ha5, 0, 0), 1'b0);
      push_req(make_req(OP_INSERT, 8'h5a, 0, 0), 1'b0);
      // reads at both ends and one at the size
      push_req(make_req(OP_READ, 0, 0, 0), 1'b0);
      push_req(make_req(OP_READ, 0, 3, 0), 1'b0);
      push_req(make_req(OP_READ, 0, 4, 0), 1'b0);
      // deletes on both sides of a moved gap, then delete after at the end
      push_req(make_req(OP_MOVE, 0, 1, 0), 1'b0);
      push_req(make_req(OP_DEL_BEFORE, 0, 0, 0), 1'b0);
      push_req(make_req(OP_DEL_AFTER, 0, 0, 0), 1'b0);
      push_req(make_req(OP_MOVE, 0, 2, 0), 1'b0);
      push_req(make_req(OP_DEL_AFTER, 0, 0, 0), 1'b0);
      // reversed range, range past the end, empty range
      push_req(make_req(OP_DEL_RANGE, 0, 2, 1), 1'b0);
      push_req(make_req(OP_DEL_RANGE, 0, 0, POS_MAX), 1'b0);
      push_req(make_req(OP_DEL_RANGE, 0, 1, 1), 1'b0);
      push_req(make_req(OP_INSERT, 8'h3c, 0, 0), 1'b0);
      // undefined code with every field bit set
      push_req(make_req(OP_UNKNOWN, 8'hff, POS_MAX, POS_MAX), 1'b0);
      push_req(make_req(OP_MOVE, 0, POS_MAX, 0), 1'b0);
      push_req(make_req(OP_DEL_RANGE, 0, 0, gen_len), 1'b0);
      push_req(make_req(OP_CLEAR, 0, 0, 0), 1'b0);

      for (n = 0; n < RANDOM_ITEMS / 2; n++)
         push_req(random_edit(), (n % 240) == 0);

      // build a longer text, then edit it with long gap moves
      push_req(make_req(OP_CLEAR, 0, 0, 0), 1'b1);
      repeat (FILL_LEN) push_req(make_req(OP_INSERT, $urandom_range(255, 0), 0, 0), 1'b0);
      push_req(make_req(OP_READ, 0, gen_len - 1, 0), 1'b0);
      push_req(make_req(OP_READ, 0, gen_len, 0), 1'b0);
      push_req(make_req(OP_MOVE, 0, gen_len + 1, 0), 1'b0);
      push_req(make_req(OP_DEL_AFTER, 0, 0, 0), 1'b0);
      push_req(make_req(OP_MOVE, 0, 0, 0), 1'b0);
      push_req(make_req(OP_DEL_BEFORE, 0, 0, 0), 1'b0);
      push_req(make_req(OP_READ, 0, 0, 0), 1'b0);
      push_req(make_req(OP_MOVE, 0, $urandom_range(gen_len - 1, 1), 0), 1'b0);
      push_req(make_req(OP_DEL_BEFORE, 0, 0, 0), 1'b0);
      push_req(make_req(OP_DEL_AFTER, 0, 0, 0), 1'b0);
      push_req(make_req(OP_INSERT, $urandom_range(255, 0), 0, 0), 1'b0);
      push_req(make_req(OP_INSERT, $urandom_range(255, 0), 0, 0), 1'b0);
      push_req(make_req(OP_INSERT, $urandom_range(255, 0), 0, 0), 1'b0);
      repeat (8) push_req(make_req(OP_READ, 0, $urandom_range(gen_len - 1, 0), 0), 1'b0);
      push_req(make_req(OP_MOVE, 0, gen_len, 0), 1'b0);
      push_req(make_req(OP_DEL_RANGE, 0, gen_len - 100, gen_len), 1'b0);
      push_req(make_req(OP_DEL_RANGE, 0, 0, gen_len), 1'b0);

      for (n = 0; n < RANDOM_ITEMS - RANDOM_ITEMS / 2; n++)
         push_req(random_edit(), (n % 240) == 0);

      // synchronous reset, released at a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (pending_reqs.size() != 0 || predicted_rsps.size() != 0) @(posedge clock);
      // run a tail to catch a stray response
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // request driver: bursts of random length with random gaps between them
   // ---------------------------------------------------------------------
   bit offering   = 1'b0;
   int burst_left = 0;
   int idle_left  = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // the request on the port went through at the last rising edge
         if (req_accepts != req_popped) begin
            void'(pending_reqs.pop_front());
            req_popped++;
            offering = 1'b0;
         end
         if (!offering) begin
            if (idle_left > 0) begin
               idle_left--;
            end else if (pending_reqs.size() != 0 &&
                         !(pending_reqs[0].drain && predicted_rsps.size() != 0)) begin
               // a drain request waits until every response has come back
               offering = 1'b1;
               req_data <= pending_reqs[0].req;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(40, 1);
                  idle_left  = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(8, 1);
               end
            end
         end
         req_valid <= offering;
      end
   end

   // ---------------------------------------------------------------------
   // response stall: patterns of random length, plus one long hold-off that
   // lets the engine fill its output register and push back on requests
   // ---------------------------------------------------------------------
   int  rx_mode      = RX_FREE;
   int  mode_left    = 0;
   int  holdoff_left = 0;
   bit  holdoff_done = 1'b0;
   bit  stall_next;

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (holdoff_left > 0) begin
            holdoff_left--;
            stall_next = 1'b1;
         end else if (!holdoff_done && rsp_seen >= HOLDOFF_AT) begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_LEN;
            stall_next   = 1'b1;
         end else begin
            if (mode_left == 0) begin
               rx_mode   = $urandom_range(RX_PERIODIC, RX_FREE);
               mode_left = $urandom_range(300, 20);
            end
            mode_left--;
            case (rx_mode)
               RX_LIGHT:    stall_next = ($urandom_range(3, 0) == 0);
               RX_HEAVY:    stall_next = ($urandom_range(9, 0) < 7);
               RX_PERIODIC: stall_next = ((mode_left % 4) == 0);
               default:     stall_next = 1'b0;
            endcase
         end
         rsp_stall <= stall_next;
      end
   end

   // ---------------------------------------------------------------------
   // monitor: predict on each accepted request, check each accepted response
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      predicted_rsp_type want;
      predicted_rsp_type fresh;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else if (!reset) begin
         if (req_valid && !req_stall) begin
            fresh.rsp = predict_response(req_data);
            fresh.seq = req_accepts;
            predicted_rsps.insert(predicted_rsps.size(), fresh);
            req_accepts++;
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_seen++;
            if (predicted_rsps.size() == 0) begin
               report_mismatch(-1, "response with none outstanding, status",
                               int'(rsp_data.status), -1);
            end else begin
               want = predicted_rsps.pop_front();
               if (rsp_data.status !== want.rsp.status)
                  report_mismatch(want.seq, "status", int'(rsp_data.status),
                                  int'(want.rsp.status));
               if (rsp_data.char_out !== want.rsp.char_out)
                  report_mismatch(want.seq, "char_out", int'(rsp_data.char_out),
                                  int'(want.rsp.char_out));
               if (rsp_data.text_size !== want.rsp.text_size)
                  report_mismatch(want.seq, "text_size", int'(rsp_data.text_size),
                                  int'(want.rsp.text_size));
               if (rsp_data.gap_pos !== want.rsp.gap_pos)
                  report_mismatch(want.seq, "gap_pos", int'(rsp_data.gap_pos),
                                  int'(want.rsp.gap_pos));
            end
         end
      end
   end

endmodule
